/* hdl/gm_pkg.sv */
`timescale 1ns / 1ps
package gm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int POS_W   = 11;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int WIN_N   = 9;
    localparam int MID_IDX = WIN_N / 2;
    localparam int N_CELLS = WIN_N;

    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    localparam logic [CFG_W-1:0] DIM_MIN = CFG_W'(3);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } t_meta;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (int'(v) > hi) begin
            r = CFG_W'(hi);
        end
        return r;
    endfunction

endpackage

/* hdl/gm_pix_if.sv */
`timescale 1ns / 1ps
interface gm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/gm_med_if.sv */
`timescale 1ns / 1ps
interface gm_med_if;
    logic        valid;
    logic        ready;
    logic [7:0]  median_value;
    logic [10:0] center_row;
    logic [10:0] center_col;
    logic        frame_done;

    modport source (output valid, output median_value, output center_row,
                    output center_col, output frame_done, input ready);
    modport sink (input valid, input median_value, input center_row,
                  input center_col, input frame_done, output ready);
endinterface

/* hdl/gm_ram.sv */
`timescale 1ns / 1ps
module gm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/gm_front.sv */
`timescale 1ns / 1ps
module gm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gm_pix_if.sink                    i_pix,
    input  logic [gm_pkg::CFG_W-1:0]  i_width_m1,
    input  logic [gm_pkg::CFG_W-1:0]  i_height_m1,
    input  logic                      i_restart,
    input  logic                      i_ready,
    output logic                      o_valid,
    output gm_pkg::t_win              o_win,
    output gm_pkg::t_meta             o_meta
);

    logic [gm_pkg::POS_W-1:0] r_row, r_col;
    logic [gm_pkg::POS_W-1:0] n_row, n_col;

    logic                       r_s1_valid;
    logic                       r_s1_emit;
    logic [gm_pkg::PIX_W-1:0]   r_s1_gray;
    logic [gm_pkg::ADDR_W-1:0]  r_s1_addr;
    gm_pkg::t_meta              r_s1_meta;
    logic [5:0][gm_pkg::PIX_W-1:0] r_win;

    logic                       s1_go, s1_ld, accept;
    logic                       col_last, row_last;
    logic [23:0]                gray_sum;
    logic [gm_pkg::PIX_W-1:0]   up, mid;

    assign s1_go   = r_s1_valid & (~r_s1_emit | i_ready);
    assign s1_ld   = ~r_s1_valid | s1_go;
    assign accept  = i_pix.valid & s1_ld;
    assign i_pix.ready = s1_ld;

    assign col_last = ({1'b0, r_col} == i_width_m1);
    assign row_last = ({1'b0, r_row} == i_height_m1);

    assign gray_sum = 24'(gm_pkg::COEF_R) * 24'(i_pix.red)
                    + 24'(gm_pkg::COEF_G) * 24'(i_pix.green)
                    + 24'(gm_pkg::COEF_B) * 24'(i_pix.blue);

    always_comb begin
        n_row = r_row;
        n_col = r_col + 1'b1;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ld) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_gray      <= gray_sum[23:16];
            r_s1_addr      <= gm_pkg::ADDR_W'(r_col);
            r_s1_emit      <= (r_row >= gm_pkg::POS_W'(2)) && (r_col >= gm_pkg::POS_W'(2));
            r_s1_meta.row  <= r_row - 1'b1;
            r_s1_meta.col  <= r_col - 1'b1;
            r_s1_meta.done <= row_last & col_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= up;
            r_win[4] <= mid;
            r_win[5] <= r_s1_gray;
        end
    end

    gm_ram #(.WIDTH(gm_pkg::PIX_W), .DEPTH(gm_pkg::MAX_WIDTH)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (mid),
        .i_re    (accept),
        .i_raddr (gm_pkg::ADDR_W'(r_col)),
        .o_rdata (up)
    );

    gm_ram #(.WIDTH(gm_pkg::PIX_W), .DEPTH(gm_pkg::MAX_WIDTH)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_gray),
        .i_re    (accept),
        .i_raddr (gm_pkg::ADDR_W'(r_col)),
        .o_rdata (mid)
    );

    assign o_valid = r_s1_valid & r_s1_emit;
    assign o_win   = {r_s1_gray, mid, up, r_win[5], r_win[4], r_win[3],
                      r_win[2], r_win[1], r_win[0]};
    assign o_meta  = r_s1_meta;

endmodule

/* hdl/gm_sort_cell.sv */
`timescale 1ns / 1ps
module gm_sort_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_phase,
    input  logic          i_valid,
    input  gm_pkg::t_win  i_win,
    input  gm_pkg::t_meta i_meta,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output gm_pkg::t_win  o_win,
    output gm_pkg::t_meta o_meta
);

    logic          r_valid;
    gm_pkg::t_win  r_win;
    gm_pkg::t_meta r_meta;
    gm_pkg::t_win  n_win;

    // odd-even transposition step
    always_comb begin
        int a;
        logic [gm_pkg::PIX_W-1:0] t;
        n_win = i_win;
        t     = '0;
        for (int p = 0; p < gm_pkg::WIN_N / 2; p++) begin
            a = 2 * p + int'(i_phase);
            if (a + 1 < gm_pkg::WIN_N) begin
                if (i_win[a] > i_win[a+1]) begin
                    t          = i_win[a];
                    n_win[a]   = i_win[a+1];
                    n_win[a+1] = t;
                end
            end
        end
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_win  <= n_win;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_win   = r_win;
    assign o_meta  = r_meta;

endmodule

/* hdl/gray_median3x3_filter_top.sv */
`timescale 1ns / 1ps
// channel  | dir | beat fields                                      | accept
// i_pix    | in  | red, green, blue                                 | valid & ready
// o_med    | out | median_value, center_row, center_col, frame_done | valid & ready
// apb      | in  | image_width @0x0, image_height @0x4              | psel & penable & pwrite
//
// One beat per cycle sustained while o_med is ready; a result is offered once its pixel
// has passed the gray and line store read stage, then nine sorting cells.
// Synchronous active-low reset clears counters, window and valid bits;
// line stores are not cleared. A config write restarts the frame at row 0.
// Each stage holds only while its successor is full and stalled.
module gray_median3x3_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gm_pix_if.sink      i_pix,
    gm_med_if.source    o_med,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [gm_pkg::CFG_W-1:0] r_width, r_height;
    logic                     cfg_wr;
    gm_pkg::t_reg_idx         reg_idx;

    logic          valid [gm_pkg::N_CELLS+1];
    logic          ready [gm_pkg::N_CELLS+1];
    gm_pkg::t_win  win   [gm_pkg::N_CELLS+1];
    gm_pkg::t_meta meta  [gm_pkg::N_CELLS+1];

    assign pready  = 1'b1;
    assign reg_idx = gm_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gm_pkg::clamp_dim(gm_pkg::CFG_W'(2048), gm_pkg::MAX_WIDTH);
            r_height <= gm_pkg::clamp_dim(gm_pkg::CFG_W'(2048), gm_pkg::MAX_HEIGHT);
        end else if (cfg_wr) begin
            case (reg_idx)
                gm_pkg::REG_WIDTH: begin
                    r_width <= gm_pkg::clamp_dim(pwdata[gm_pkg::CFG_W-1:0], gm_pkg::MAX_WIDTH);
                end
                gm_pkg::REG_HEIGHT: begin
                    r_height <= gm_pkg::clamp_dim(pwdata[gm_pkg::CFG_W-1:0],
                                                  gm_pkg::MAX_HEIGHT);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gm_pkg::REG_WIDTH:  prdata = 32'(r_width);
            gm_pkg::REG_HEIGHT: prdata = 32'(r_height);
            default:            prdata = '0;
        endcase
    end

    gm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_width_m1  (r_width - 1'b1),
        .i_height_m1 (r_height - 1'b1),
        .i_restart   (cfg_wr),
        .i_ready     (ready[0]),
        .o_valid     (valid[0]),
        .o_win       (win[0]),
        .o_meta      (meta[0])
    );

    for (genvar k = 0; k < gm_pkg::N_CELLS; k++) begin : g_cell
        gm_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_phase (1'(k % 2)),
            .i_valid (valid[k]),
            .i_win   (win[k]),
            .i_meta  (meta[k]),
            .o_ready (ready[k]),
            .i_ready (ready[k+1]),
            .o_valid (valid[k+1]),
            .o_win   (win[k+1]),
            .o_meta  (meta[k+1])
        );
    end

    assign ready[gm_pkg::N_CELLS] = o_med.ready;
    assign o_med.valid        = valid[gm_pkg::N_CELLS];
    assign o_med.median_value = win[gm_pkg::N_CELLS][gm_pkg::MID_IDX];
    assign o_med.center_row   = meta[gm_pkg::N_CELLS].row;
    assign o_med.center_col   = meta[gm_pkg::N_CELLS].col;
    assign o_med.frame_done   = meta[gm_pkg::N_CELLS].done;

endmodule

/* sim/gm_median_checker.sv */
`timescale 1ns / 1ps
module gm_median_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gm_pix_if           i_pix,
    gm_med_if           i_med,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    // luma weights, 16-bit fixed point
    localparam int unsigned LUMA_R = 19595;
    localparam int unsigned LUMA_G = 38470;
    localparam int unsigned LUMA_B = 7471;

    typedef struct packed {
        logic [7:0]  median_value;
        logic [10:0] center_row;
        logic [10:0] center_col;
        logic        frame_done;
    } median_beat_t;

    median_beat_t    expected_medians[$];
    median_beat_t    want;
    logic [7:0]      upper_row  [0:gm_pkg::MAX_WIDTH-1];
    logic [7:0]      middle_row [0:gm_pkg::MAX_WIDTH-1];
    logic [5:0][7:0] window;
    int unsigned     img_w;
    int unsigned     img_h;
    int unsigned     row_pos;
    int unsigned     col_pos;
    int              fails = 0;
    int              results = 0;

    function automatic int unsigned fit_dim(input logic [11:0] v, input int unsigned hi);
        if (v < 12'd3) return 3;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [7:0] median_of9(input logic [8:0][7:0] v);
        int         below;
        int         not_above;
        logic [7:0] m;
        m = v[0];
        for (int i = 0; i < 9; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++) begin
                if (v[j] < v[i]) below++;
                if (v[j] <= v[i]) not_above++;
            end
            if (below <= 4 && not_above >= 5) m = v[i];
        end
        return m;
    endfunction

    task automatic take_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic [7:0]   gray;
        logic [7:0]   up;
        logic [7:0]   mid;
        median_beat_t beat;
        gray = 8'((LUMA_R * r + LUMA_G * g + LUMA_B * b) >> 16);
        up = upper_row[col_pos];
        mid = middle_row[col_pos];
        if (row_pos >= 2 && col_pos >= 2) begin
            beat.median_value = median_of9({window, up, mid, gray});
            beat.center_row = 11'(row_pos - 1);
            beat.center_col = 11'(col_pos - 1);
            beat.frame_done = (row_pos == img_h - 1) && (col_pos == img_w - 1);
            expected_medians.push_back(beat);
        end
        window = {window[2:0], up, mid, gray};
        upper_row[col_pos] = mid;
        middle_row[col_pos] = gray;
        col_pos++;
        if (col_pos >= img_w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= img_h) row_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            img_w = gm_pkg::MAX_WIDTH;
            img_h = gm_pkg::MAX_HEIGHT;
            row_pos = 0;
            col_pos = 0;
            window = '0;
            for (int k = 0; k < gm_pkg::MAX_WIDTH; k++) begin
                upper_row[k] = '0;
                middle_row[k] = '0;
            end
            expected_medians.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (gm_pkg::t_reg_idx'(i_paddr[2]) == gm_pkg::REG_WIDTH) begin
                    img_w = fit_dim(i_pwdata[11:0], gm_pkg::MAX_WIDTH);
                end else begin
                    img_h = fit_dim(i_pwdata[11:0], gm_pkg::MAX_HEIGHT);
                end
                row_pos = 0;
                col_pos = 0;
            end
            if (i_pix.valid && i_pix.ready) begin
                take_pixel(i_pix.red, i_pix.green, i_pix.blue);
            end
            if (i_med.valid && i_med.ready) begin
                results++;
                if (expected_medians.size() == 0) begin
                    $error("median beat at row %0d col %0d with nothing pending",
                           i_med.center_row, i_med.center_col);
                    fails++;
                end else begin
                    want = expected_medians.pop_front();
                    if (i_med.median_value !== want.median_value) begin
                        $error("median_value exp %0d got %0d", want.median_value,
                               i_med.median_value);
                        fails++;
                    end
                    if (i_med.center_row !== want.center_row) begin
                        $error("center_row exp %0d got %0d", want.center_row,
                               i_med.center_row);
                        fails++;
                    end
                    if (i_med.center_col !== want.center_col) begin
                        $error("center_col exp %0d got %0d", want.center_col,
                               i_med.center_col);
                        fails++;
                    end
                    if (i_med.frame_done !== want.frame_done) begin
                        $error("frame_done exp %0d got %0d", want.frame_done,
                               i_med.frame_done);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_medians.size();
        o_result_count <= results;
    end

endmodule

/* sim/gray_median3x3_filter_top_tb.sv */
`timescale 1ns / 1ps
module gray_median3x3_filter_top_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_PIXELS = 800;
    localparam int WIDE_PIXELS   = 200;
    localparam int TALL_PIXELS   = 600;
    localparam int HOLD_PIXELS   = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 18;

    // two 3x3 frames of corner-case colors, first pixel in the top slice
    localparam logic [18*24-1:0] DIRECTED_PIX = {
        24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'h808080,
        24'h7f7f7f, 24'hffff00, 24'h00ffff,
        24'hff00ff, 24'h010101, 24'hfefefe, 24'h800000, 24'h008000, 24'h000080,
        24'hffffff, 24'hffffff, 24'hffffff
    };

    typedef enum int {
        PIX_RANDOM,
        PIX_SPECKLE,
        PIX_FLAT
    } pix_style_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count;
    int pixels_sent = 0;
    int setups_run = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit no_idle = 1'b0;

    gm_pix_if pix_bus ();
    gm_med_if med_bus ();

    gray_median3x3_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_med   (med_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gm_median_checker median_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (pix_bus),
        .i_med          (med_bus),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [23:0] pick_rgb(input pix_style_t style);
        logic [7:0] level;
        case (style)
            PIX_SPECKLE: begin
                level = 8'($urandom_range(90, 110));
                case ($urandom_range(0, 9))
                    0: return 24'h000000;
                    1: return 24'hffffff;
                    default: return {level, level ^ 8'($urandom_range(0, 3)), level};
                endcase
            end
            PIX_FLAT: begin
                level = 8'($urandom_range(0, 3) * 85);
                return {3{level}};
            end
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [23:0] rgb);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            pix_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        {pix_bus.red, pix_bus.green, pix_bus.blue} <= rgb;
        do @(posedge i_clk); while (!pix_bus.ready);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input pix_style_t style);
        for (int k = 0; k < count; k++) send_pixel(pick_rgb(style));
    endtask

    // drop valid, wait for every pending median, then let the pipe empty
    task automatic settle(input int extra);
        pix_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input gm_pkg::t_reg_idx idx, input logic [11:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {20'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // sink side: random stalls plus requested long hold-offs
    initial begin
        med_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                med_bus.ready <= 1'b0;
                hold_left--;
            end else if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                med_bus.ready <= 1'b0;
            end else begin
                med_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[gray_median3x3_filter_top] ERROR");
        $finish;
    end

    initial begin
        int          random_pixels;
        int          frames;
        int          count;
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned cur_w;
        int unsigned cur_h;
        pix_style_t  style;

        i_rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.red = '0;
        pix_bus.green = '0;
        pix_bus.blue = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        random_pixels = 0;
        cur_w = 3;
        cur_h = 3;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: low clamp on both sizes, two 3x3 frames back to back
        write_reg(gm_pkg::REG_WIDTH, 12'd0);
        write_reg(gm_pkg::REG_HEIGHT, 12'd2);
        for (int k = 0; k < 18; k++) send_pixel(DIRECTED_PIX[(17 - k) * 24 +: 24]);
        settle(DRAIN_CYCLES);
        setups_run++;

        // high clamp on both sizes, well short of a row end: no median may appear
        write_reg(gm_pkg::REG_WIDTH, 12'hfff);
        write_reg(gm_pkg::REG_HEIGHT, 12'hfff);
        send_run(WIDE_PIXELS, PIX_RANDOM);
        settle(DRAIN_CYCLES);
        setups_run++;

        // three columns under the clamped height, source pauses until drained mid-frame
        write_reg(gm_pkg::REG_WIDTH, 12'd3);
        send_run(TALL_PIXELS / 2, PIX_RANDOM);
        settle(0);
        send_run(TALL_PIXELS - TALL_PIXELS / 2, PIX_FLAT);
        settle(DRAIN_CYCLES);
        setups_run++;

        // no idling, one long sink hold-off while the source keeps offering
        write_reg(gm_pkg::REG_WIDTH, 12'd16);
        write_reg(gm_pkg::REG_HEIGHT, 12'd25);
        no_idle = 1'b1;
        send_run(HOLD_PIXELS / 2, PIX_RANDOM);
        hold_requests++;
        send_run(HOLD_PIXELS - HOLD_PIXELS / 2, PIX_SPECKLE);
        settle(DRAIN_CYCLES);
        no_idle = 1'b0;
        setups_run++;

        while (random_pixels < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0: raw_w = $urandom_range(0, 2);
                1, 2: raw_w = $urandom_range(11, 40);
                default: raw_w = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
                0: raw_h = $urandom_range(0, 2);
                default: raw_h = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    write_reg(gm_pkg::REG_WIDTH, 12'(raw_w));
                    cur_w = (raw_w < 3) ? 3 : raw_w;
                end
                1: begin
                    write_reg(gm_pkg::REG_HEIGHT, 12'(raw_h));
                    cur_h = (raw_h < 3) ? 3 : raw_h;
                end
                default: begin
                    write_reg(gm_pkg::REG_WIDTH, 12'(raw_w));
                    write_reg(gm_pkg::REG_HEIGHT, 12'(raw_h));
                    cur_w = (raw_w < 3) ? 3 : raw_w;
                    cur_h = (raw_h < 3) ? 3 : raw_h;
                end
            endcase
            frames = $urandom_range(1, 3);
            count = frames * cur_w * cur_h;
            // cut some runs off mid-frame so the next write restarts it
            if ($urandom_range(0, 3) == 0) count += $urandom_range(0, cur_w * cur_h - 1);
            style = pix_style_t'($urandom_range(0, 2));
            no_idle = ($urandom_range(0, 7) == 0);
            send_run(count, style);
            random_pixels += count;
            settle(DRAIN_CYCLES);
            no_idle = 1'b0;
            setups_run++;
        end

        $display("covered %0d pixels over %0d size setups, from clamped 3x3 to clamped 2048",
                 pixels_sent, setups_run);
        $display("%0d medians compared, %0d mismatches", result_count, fail_count);
        if (fail_count == 0) begin
            $display("[gray_median3x3_filter_top] OK");
        end else begin
            $display("[gray_median3x3_filter_top] ERROR");
        end
        $finish;
    end

endmodule
